/* design/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median
// Holds default parameter values, the port widths fixed by the stream and
// register formats, and the status group passed from the front to the back.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_W      = 33;
    localparam int OUT_DATA_W = 40;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int WS_W       = 6;
    localparam logic [WS_W-1:0] WS_RESET = 6'd3;
    // Word index of the window_size register (paddr bit 2).
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic valid;
        logic restart;
    } fe_status_t;

endpackage

/* design/swm_front.sv */
// ----------------------------------------------------------------------------
// swm_front: input side of the sliding window median
// Accepts sample transactions, reads the sample as signed and queues it with
// its restart flag in a short queue that the back drains.
// ----------------------------------------------------------------------------
module swm_front #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swm_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [31:0] sample
    input  logic                              s_axis_tuser,   // [0] restart
    output swm_pkg::fe_status_t               fe_status,
    output logic signed [SAMPLE_WIDTH-1:0]    fe_sample,
    input  logic                              fe_pop
);
    import swm_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [SAMPLE_WIDTH-1:0] q_sample_reg [QUEUE_DEPTH];
    logic                           q_restart_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]              count_reg, count_next;
    logic                           push, pop;

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = fe_pop && (count_reg != '0);

    assign fe_status.valid   = (count_reg != '0);
    assign fe_status.restart = q_restart_reg[rd_ptr_reg];
    assign fe_sample         = q_sample_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The sample is taken from the low SAMPLE_WIDTH bits and read as signed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_sample_reg[wr_ptr_reg]  <= signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]);
            q_restart_reg[wr_ptr_reg] <= s_axis_tuser;
        end
    end

endmodule

/* design/swm_back.sv */
// ----------------------------------------------------------------------------
// swm_back: window update and median output
// Keeps the history ring in a memory and the sorted window in a row of
// compare-and-shift cells, and loads each median into the output register.
// ----------------------------------------------------------------------------
module swm_back #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swm_pkg::fe_status_t                 fe_status,
    input  logic signed [SAMPLE_WIDTH-1:0]      fe_sample,
    output logic                                fe_pop,
    input  logic                                cfg_clear,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]     k_eff,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [swm_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // [32:0] median_doubled
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               fill_reg;
    logic [IDX_W-1:0]               pos_reg;
    logic [CNT_W-1:0]               fill_lat_reg;
    logic [IDX_W-1:0]               pos_lat_reg;
    logic [IDX_W-1:0]               wr_addr_reg;
    logic                           full_reg;
    logic                           emit_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [OUT_W-1:0]               out_data_reg;
    logic                           out_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;

    logic signed [SAMPLE_WIDTH-1:0] s_reg  [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] s_next [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] t_val  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          le, gev, t_le_raw, tle;

    logic                           clear_now;
    logic [CNT_W-1:0]               fill_eff;
    logic [IDX_W-1:0]               pos_eff;
    logic                           full_eff;
    logic [CNT_W-1:0]               n_t;
    logic [CNT_W-1:0]               fill_inc;
    logic [CNT_W-1:0]               pos_inc;
    logic [CNT_W-1:0]               mid_lo, mid_hi;
    logic signed [SAMPLE_WIDTH-1:0] lo_val, hi_val;
    logic signed [SAMPLE_WIDTH:0]   mid_sum;
    logic                           out_free;
    logic                           load_out;

    assign fe_pop        = (state_reg == ST_IDLE) && fe_status.valid;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_out      = (state_reg == ST_EMIT) && emit_reg && out_free;

    // A restart, or a count left over from a larger window, empties the window.
    assign clear_now = fe_status.restart || (fill_reg > k_eff);
    assign fill_eff  = clear_now ? '0 : fill_reg;
    assign pos_eff   = (clear_now || (CNT_W'(pos_reg) >= k_eff)) ? '0 : pos_reg;
    assign full_eff  = (fill_eff == k_eff);

    assign n_t      = full_reg ? (k_eff - 1'b1) : fill_lat_reg;
    assign fill_inc = fill_lat_reg + 1'b1;
    assign pos_inc  = CNT_W'(pos_lat_reg) + 1'b1;

    // Each cell removes the lowest copy of the oldest sample and makes room
    // for the new one using only its own compares and its neighbors'.
    generate
        for (genvar gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            assign le[gi]  = (s_reg[gi] <= x_reg);
            assign gev[gi] = full_reg && (s_reg[gi] >= rd_data_reg);
            if (gi < WINDOW_MAX - 1)
            begin : g_inner
                assign t_val[gi]    = gev[gi] ? s_reg[gi+1] : s_reg[gi];
                assign t_le_raw[gi] = gev[gi] ? le[gi+1] : le[gi];
            end
            else
            begin : g_last
                assign t_val[gi]    = s_reg[gi];
                assign t_le_raw[gi] = le[gi];
            end
            assign tle[gi] = (CNT_W'(gi) < n_t) && t_le_raw[gi];
            if (gi == 0)
            begin : g_first
                assign s_next[gi] = tle[gi] ? t_val[gi] : x_reg;
            end
            else
            begin : g_rest
                assign s_next[gi] = tle[gi] ? t_val[gi] :
                                    (tle[gi-1] ? x_reg : t_val[gi-1]);
            end
        end
    endgenerate

    // The two middle cells coincide for an odd window.
    assign mid_lo = (k_eff - 1'b1) >> 1;
    assign mid_hi = k_eff >> 1;

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (CNT_W'(i) == mid_lo)
            begin
                lo_val = lo_val | s_reg[i];
            end
            if (CNT_W'(i) == mid_hi)
            begin
                hi_val = hi_val | s_reg[i];
            end
        end
        mid_sum = (SAMPLE_WIDTH+1)'(lo_val) + (SAMPLE_WIDTH+1)'(hi_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pos_reg       <= '0;
            fill_lat_reg  <= '0;
            pos_lat_reg   <= '0;
            wr_addr_reg   <= '0;
            full_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            x_reg         <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_data_reg  <= OUT_W'(mid_sum);
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // A window_size write empties the window.
            if (cfg_clear)
            begin
                fill_reg <= '0;
                pos_reg  <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                if (full_reg)
                begin
                    fill_reg <= fill_lat_reg;
                    pos_reg  <= (pos_inc >= k_eff) ? '0 : pos_inc[IDX_W-1:0];
                end
                else
                begin
                    fill_reg <= fill_inc;
                    pos_reg  <= '0;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fe_status.valid)
                    begin
                        x_reg        <= fe_sample;
                        full_reg     <= full_eff;
                        fill_lat_reg <= fill_eff;
                        pos_lat_reg  <= pos_eff;
                        wr_addr_reg  <= full_eff ? pos_eff : fill_eff[IDX_W-1:0];
                        state_reg    <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    emit_reg  <= full_reg || (fill_inc == k_eff);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!emit_reg || out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // History ring: one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            ring_mem[wr_addr_reg] <= x_reg;
        end
        if (fe_pop)
        begin
            rd_data_reg <= ring_mem[pos_eff];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                s_reg[i] <= s_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_update_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |-> $past(state_reg) == ST_IDLE)
        else $error("update entered without a dequeued item");
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_eff)
        else $error("fill count exceeds the window size");
    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) || (CNT_W'(pos_reg) < k_eff))
        else $error("ring position outside the window");
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT && emit_reg))
        else $error("result loaded outside the emit step");
`endif

endmodule

/* design/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median: running median over a sliding window of samples
// Input transactions carry a signed sample in s_axis_tdata and a restart
// flag in s_axis_tuser. Once the window holds window_size samples, every
// input transaction yields one output transaction whose m_axis_tdata holds
// the median doubled (sum of the two middle values, or twice the middle one)
// as a 33-bit signed value. While the window fills no result is produced.
// The window length is set through the APB register at address 0 (reset 3,
// 0 acts as 1, values above WINDOW_MAX saturate); writing it empties the
// window. Write it only while no transaction is in flight.
// The back handles one item at a time, in order: dequeue and ring read,
// sorted cell update, output load; only after leaving the output step does
// it dequeue the next item, so items never overlap in the back.
// A two-entry queue lets the input side accept ahead of the back.
// When the receiver stalls, the result waits in the output register and the
// back waits in its output step; the queue keeps accepting until full.
// Reset empties the window, the queue and the output register.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swm_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // [31:0] sample
    input  logic                                s_axis_tuser,   // [0] restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [swm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [32:0] median_doubled
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KC_W  = (CNT_W > WS_W) ? CNT_W : WS_W;

    logic [WS_W-1:0]        window_size_reg;
    logic                   cfg_wr;
    logic [KC_W-1:0]        ws_ext;
    logic [KC_W-1:0]        k_sat;
    logic [CNT_W-1:0]       k_eff;
    fe_status_t             fe_status;
    logic signed [SAMPLE_WIDTH-1:0] fe_sample;
    logic                   fe_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(window_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_RESET;
        end
        else if (cfg_wr)
        begin
            window_size_reg <= pwdata[WS_W-1:0];
        end
    end

    always_comb
    begin
        ws_ext = KC_W'(window_size_reg);
        if (ws_ext == '0)
        begin
            k_sat = KC_W'(1);
        end
        else if (ws_ext > KC_W'(WINDOW_MAX))
        begin
            k_sat = KC_W'(WINDOW_MAX);
        end
        else
        begin
            k_sat = ws_ext;
        end
        k_eff = k_sat[CNT_W-1:0];
    end

    swm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fe_status     (fe_status),
        .fe_sample     (fe_sample),
        .fe_pop        (fe_pop)
    );

    swm_back #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fe_status     (fe_status),
        .fe_sample     (fe_sample),
        .fe_pop        (fe_pop),
        .cfg_clear     (cfg_wr),
        .k_eff         (k_eff),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* dv/tb_sliding_window_median.sv */
// ----------------------------------------------------------------------------
// tb_sliding_window_median: self-checking bench for the sliding window median
// Feeds signed samples with restart flags into the block under several
// window sizes, predicts every doubled median, and compares each output
// transaction against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

    import swm_pkg::*;

    localparam int WINDOW_MAX    = WINDOW_MAX_DEF;
    localparam int SETTLE_CYCLES = 30;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = {~REG_WINDOW_SIZE, 2'b00};

    localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;

    typedef struct {
        logic [31:0] sample;
        logic        restart;
    } sample_item_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata   = '0;   // [31:0] sample
    logic                   s_axis_tuser   = 1'b0; // [0] restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;          // [32:0] median_doubled
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr          = '0;
    logic [APB_DATA_W-1:0]  pwdata         = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Window predictor state.
    logic [WS_W-1:0]        win_size = WS_RESET;
    int                     win_fill = 0;
    int                     oldest_slot = 0;
    logic signed [31:0]     arrival_ring [WINDOW_MAX];
    logic signed [31:0]     sorted_win [WINDOW_MAX];

    sample_item_t           sample_q [$];
    logic signed [32:0]     median_q [$];
    sample_item_t           drive_item;
    logic signed [32:0]     pred_median;
    logic signed [32:0]     exp_median;
    int                     items_queued   = 0;
    int                     items_accepted = 0;
    int                     n_errors       = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;
    int                     send_gap       = 0;
    int                     recv_stall     = 0;

    sliding_window_median i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Places v after every equal or smaller entry among the first n.
    function automatic void sorted_insert(input int n, input logic signed [31:0] v);
        int i;
        i = n;
        while (i > 0 && sorted_win[i-1] > v)
        begin
            sorted_win[i] = sorted_win[i-1];
            i--;
        end
        sorted_win[i] = v;
    endfunction

    function automatic bit window_step(input logic signed [31:0] s, input logic restart,
                                       output logic signed [32:0] med);
        int k;
        int i;
        logic signed [31:0] oldest;
        k = (win_size == 0) ? 1 : ((win_size > WINDOW_MAX) ? WINDOW_MAX : int'(win_size));
        if (restart || win_fill > k)
        begin
            win_fill    = 0;
            oldest_slot = 0;
        end
        if (oldest_slot >= k)
            oldest_slot = 0;
        if (win_fill < k)
        begin
            arrival_ring[win_fill] = s;
            sorted_insert(win_fill, s);
            win_fill++;
            oldest_slot = 0;
        end
        else
        begin
            // Drop the first copy of the oldest sample, then close the gap.
            oldest = arrival_ring[oldest_slot];
            i = 0;
            while (i < k && sorted_win[i] != oldest)
                i++;
            while (i + 1 < k)
            begin
                sorted_win[i] = sorted_win[i+1];
                i++;
            end
            sorted_insert(k - 1, s);
            arrival_ring[oldest_slot] = s;
            oldest_slot++;
            if (oldest_slot >= k)
                oldest_slot = 0;
        end
        med = '0;
        if (win_fill < k)
            return 1'b0;
        if (k % 2 == 1)
            med = {sorted_win[k/2], 1'b0};
        else
            med = $signed({sorted_win[k/2-1][31], sorted_win[k/2-1]})
                + $signed({sorted_win[k/2][31], sorted_win[k/2]});
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(8) - 4;
        if (r < 60)
        begin
            case ($urandom_range(4))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return 32'hFFFF_FFFF;
                3: return 32'h0000_0000;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    // Stream driver.
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end
            else if (sample_q.size() > 0)
            begin
                drive_item = sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drive_item.sample;
                s_axis_tuser  <= drive_item.restart;
                if ($urandom_range(99) < send_idle_pct)
                    send_gap = $urandom_range(13, 1);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls.
    always @(posedge clk)
    begin
        if (recv_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(99) < recv_idle_pct)
                recv_stall = $urandom_range(13, 1);
        end
    end

    // Monitor: predicts on each accepted input, then checks each output transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (window_step($signed(s_axis_tdata[31:0]), s_axis_tuser, pred_median))
                    median_q = {median_q, pred_median};
                items_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (median_q.size() == 0)
                begin
                    $error("median_doubled: expected none, actual %0d",
                           $signed(m_axis_tdata[OUT_W-1:0]));
                    n_errors++;
                end
                else
                begin
                    exp_median = median_q.pop_front();
                    if (m_axis_tdata[OUT_W-1:0] !== exp_median)
                    begin
                        $error("median_doubled: expected %0d, actual %0d",
                               exp_median, $signed(m_axis_tdata[OUT_W-1:0]));
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic push_one(input logic [31:0] sample, input logic restart);
        sample_item_t item;
        item.sample  = sample;
        item.restart = restart;
        sample_q = {sample_q, item};
        items_queued++;
    endtask

    task automatic push_random(input int n, input int restart_pct);
        for (int i = 0; i < n; i++)
            push_one(pick_sample(), $urandom_range(99) < restart_pct);
    endtask

    // Waits until every transaction has gone through and the block has settled.
    task automatic wait_drained();
        while (items_accepted != items_queued || median_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WINDOW_SIZE)
        begin
            win_size    = data[WS_W-1:0];
            win_fill    = 0;
            oldest_slot = 0;
        end
    endtask

    task automatic run_phase(input logic [WS_W-1:0] size, input int n, input int restart_pct,
                             input int send_pct, input int recv_pct);
        wait_drained();
        reg_write(ADDR_WINDOW_SIZE, ($urandom() & 32'hFFFF_FFC0) | 32'(size));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        push_random(n, restart_pct);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of three: extremes, equal samples, restarts full and mid-fill.
        send_idle_pct = 30;
        recv_idle_pct = 30;
        push_one(SAMPLE_MAX, 1'b0);
        push_one(SAMPLE_MAX, 1'b0);
        push_one(SAMPLE_MAX, 1'b0);
        push_one(SAMPLE_MIN, 1'b0);
        push_one(SAMPLE_MIN, 1'b0);
        push_one(SAMPLE_MIN, 1'b0);
        push_one(32'd5, 1'b1);
        push_one(32'd5, 1'b0);
        push_one(32'd5, 1'b0);
        push_one(32'd5, 1'b0);
        push_one(32'hFFFF_FFFF, 1'b1);
        push_one(32'd0, 1'b0);
        push_one(32'd1, 1'b1);
        push_one(32'd1, 1'b0);
        push_one(32'd2, 1'b0);

        // Even window: sums of the largest and smallest pairs.
        wait_drained();
        reg_write(ADDR_WINDOW_SIZE, 32'd2);
        push_one(SAMPLE_MAX, 1'b0);
        push_one(SAMPLE_MAX, 1'b0);
        push_one(SAMPLE_MIN, 1'b0);
        push_one(SAMPLE_MIN, 1'b0);
        push_one(SAMPLE_MAX, 1'b0);

        // A write to an unmapped register must leave the window intact.
        wait_drained();
        reg_write(ADDR_UNMAPPED, 32'd7);
        push_one(32'd0, 1'b0);
        push_one(32'hFFFF_FFFF, 1'b0);

        run_phase(6'd1,  150, 5, 20, 20);
        run_phase(6'd32, 300, 1, 30, 30);
        run_phase(6'd0,  100, 5,  0,  0);
        run_phase(6'd63, 250, 1, 10, 40);
        run_phase(6'd5,  200, 3, 40, 10);
        run_phase(6'd4,  200, 3, 25, 25);
        run_phase(6'($urandom_range(31, 1)), 200, 2, 25, 25);
        run_phase(6'd2,  150, 3, 20, 20);
        run_phase(6'd7,  200, 3,  0,  0);

        wait_drained();
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
design/swm_pkg.sv
design/swm_front.sv
design/swm_back.sv
design/sliding_window_median.sv
dv/tb_sliding_window_median.sv
